@@ rtl/tlt_pkg.sv @@
`timescale 1ns / 1ps

package tlt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int TIME_W   = 48;
  localparam int CARD_W   = 16;
  localparam int CALLER_W = 32;
  localparam int CMD_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST = 48'd1000000;
  localparam logic [TIME_W-1:0] MAX_LIFETIME_RST = 48'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_TIMEOUT = 2'd0,
    CFG_MAX_LIFETIME = 2'd1
  } cfg_reg_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_GRANT         = 4'd0,
    CMD_IS_ACTIVE     = 4'd1,
    CMD_TOUCH         = 4'd2,
    CMD_PIN_QUERY     = 4'd3,
    CMD_PIN_SET       = 4'd4,
    CMD_PIN_CLEAR     = 4'd5,
    CMD_REVOKE        = 4'd6,
    CMD_REVOKE_CARD   = 4'd7,
    CMD_REVOKE_CALLER = 4'd8
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [CARD_W-1:0]   card_id;
    logic [CALLER_W-1:0] caller_id;
    logic [TIME_W-1:0]   now;
  } req_t;

  typedef struct packed {
    logic answer;
    logic table_full;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic exec;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_stall;
  } ctl_sts_t;

endpackage

@@ rtl/tlt_ctrl.sv @@
`timescale 1ns / 1ps

module tlt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tlt_pkg::ctl_sts_t sts_i,
  output tlt_pkg::ctl_cmd_t cmd_o
);
  import tlt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts_i.out_stall) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_exec_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> state_q == ST_EXEC)
    else $error("exec outside exec state");

  a_capture_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == ST_SCAN)
    else $error("capture did not start scan");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.capture, cmd_o.step, cmd_o.exec}))
    else $error("overlapping commands");

endmodule

@@ rtl/tlt_dpath.sv @@
`timescale 1ns / 1ps

module tlt_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlt_pkg::TIME_W-1:0]     cfg_data_i,
  input  tlt_pkg::req_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tlt_pkg::rsp_t                  out_data_o,
  input  tlt_pkg::ctl_cmd_t              cmd_i,
  output tlt_pkg::ctl_sts_t              sts_o
);
  import tlt_pkg::*;

  logic [TIME_W-1:0]   idle_timeout_q, max_lifetime_q;
  req_t                item_q;
  logic [IDX_W-1:0]    scan_idx_q, hit_idx_q, free_idx_q;
  logic                hit_found_q, free_found_q;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [CARD_W-1:0]   card_q   [ENTRIES];
  logic [CALLER_W-1:0] caller_q [ENTRIES];
  logic [TIME_W-1:0]   last_q   [ENTRIES];
  logic [TIME_W-1:0]   origin_q [ENTRIES];
  logic                pin_q    [ENTRIES];
  logic                out_valid_q;
  rsp_t                out_q, rsp_d;

  logic [IDX_W-1:0]    rd_idx, wr_idx;
  logic [CARD_W-1:0]   rd_card;
  logic [CALLER_W-1:0] rd_caller;
  logic [TIME_W-1:0]   rd_last, rd_origin;
  logic                rd_pin, rd_valid;
  logic                card_eq, caller_eq, match;
  logic                idle_hit, life_hit, live;
  logic                we_key, we_last, we_pin, pin_wdata;

  assign rd_idx    = cmd_i.exec ? hit_idx_q : scan_idx_q;
  assign wr_idx    = hit_found_q ? hit_idx_q : free_idx_q;
  assign rd_card   = card_q[rd_idx];
  assign rd_caller = caller_q[rd_idx];
  assign rd_last   = last_q[rd_idx];
  assign rd_origin = origin_q[rd_idx];
  assign rd_pin    = pin_q[rd_idx];
  assign rd_valid  = valid_q[rd_idx];
  assign card_eq   = rd_card == item_q.card_id;
  assign caller_eq = rd_caller == item_q.caller_id;
  assign match     = rd_valid && card_eq && caller_eq;

  assign idle_hit = (item_q.now >= rd_last) &&
                    ((item_q.now - rd_last) >= idle_timeout_q);
  assign life_hit = (max_lifetime_q != '0) && (item_q.now >= rd_origin) &&
                    ((item_q.now - rd_origin) >= max_lifetime_q);
  assign live     = !idle_hit && !life_hit;

  assign sts_o.scan_last = scan_idx_q == IDX_W'(ENTRIES - 1);
  assign sts_o.out_stall = out_valid_q && !out_ready_i;

  always_comb begin
    valid_d   = valid_q;
    rsp_d     = '0;
    we_key    = 1'b0;
    we_last   = 1'b0;
    we_pin    = 1'b0;
    pin_wdata = 1'b0;
    if (cmd_i.step) begin
      if (item_q.cmd == CMD_REVOKE_CARD && rd_valid && card_eq) begin
        valid_d[rd_idx] = 1'b0;
      end
      if (item_q.cmd == CMD_REVOKE_CALLER && rd_valid && caller_eq) begin
        valid_d[rd_idx] = 1'b0;
      end
    end
    if (cmd_i.exec) begin
      case (item_q.cmd)
        CMD_GRANT: begin
          if (hit_found_q) begin
            we_last = 1'b1;
            we_pin  = 1'b1;
          end else if (free_found_q) begin
            we_key          = 1'b1;
            we_last         = 1'b1;
            we_pin          = 1'b1;
            valid_d[wr_idx] = 1'b1;
          end else begin
            rsp_d.table_full = 1'b1;
          end
        end
        CMD_IS_ACTIVE, CMD_TOUCH: begin
          if (hit_found_q) begin
            if (live) begin
              rsp_d.answer = 1'b1;
              we_last      = item_q.cmd == CMD_TOUCH;
            end else begin
              valid_d[rd_idx] = 1'b0;
            end
          end
        end
        CMD_PIN_QUERY: begin
          rsp_d.answer = hit_found_q && rd_pin;
        end
        CMD_PIN_SET: begin
          we_pin    = hit_found_q;
          pin_wdata = 1'b1;
        end
        CMD_PIN_CLEAR: begin
          we_pin = hit_found_q;
        end
        CMD_REVOKE: begin
          if (hit_found_q) begin
            valid_d[rd_idx] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_timeout_q <= IDLE_TIMEOUT_RST;
      max_lifetime_q <= MAX_LIFETIME_RST;
      valid_q        <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_IDLE_TIMEOUT) begin
        idle_timeout_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_MAX_LIFETIME) begin
        max_lifetime_q <= cfg_data_i;
      end
      valid_q <= valid_d;
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q       <= in_data_i;
      scan_idx_q   <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      hit_idx_q    <= '0;
      free_idx_q   <= '0;
    end
    if (cmd_i.step) begin
      scan_idx_q <= scan_idx_q + 1'b1;
      if (!hit_found_q && match) begin
        hit_found_q <= 1'b1;
        hit_idx_q   <= scan_idx_q;
      end
      if (!free_found_q && !rd_valid) begin
        free_found_q <= 1'b1;
        free_idx_q   <= scan_idx_q;
      end
    end
    if (cmd_i.exec) begin
      out_q <= rsp_d;
    end
    if (we_key) begin
      card_q[wr_idx]   <= item_q.card_id;
      caller_q[wr_idx] <= item_q.caller_id;
      origin_q[wr_idx] <= item_q.now;
    end
    if (we_last) begin
      last_q[wr_idx] <= item_q.now;
    end
    if (we_pin) begin
      pin_q[wr_idx] <= pin_wdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_exec_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten while stalled");

  a_full_only_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && rsp_d.table_full |->
      item_q.cmd == CMD_GRANT && !hit_found_q && !free_found_q)
    else $error("table_full without a refused grant");

  a_grant_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && item_q.cmd == CMD_GRANT && free_found_q && !hit_found_q
      |=> valid_q[$past(free_idx_q)])
    else $error("grant did not mark entry valid");

  a_scan_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |=> scan_idx_q == '0 && !hit_found_q && !free_found_q)
    else $error("scan not restarted on capture");

endmodule

@@ rtl/timed_lease_table_top.sv @@
`timescale 1ns / 1ps

// Lease table of ENTRIES slots keyed by card and caller. Each command steps
// through capture of the input beat, a key and free-slot scan of every slot
// over the single table read port, and an exec step that applies the update
// and loads the result register, held off while the previous result stalls.
// A new beat is taken as soon as the previous command has loaded its result,
// even if that result is still waiting on out_ready_i. The table is empty
// after reset with no clearing pass. Write idle_timeout (index 0) and
// max_lifetime (index 1, zero for no limit) only while idle.

module timed_lease_table_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlt_pkg::TIME_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tlt_pkg::req_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tlt_pkg::rsp_t                  out_data_o
);
  import tlt_pkg::*;

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  tlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (ctl_sts),
    .cmd_o      (ctl_cmd)
  );

  tlt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (ctl_cmd),
    .sts_o       (ctl_sts)
  );

endmodule
